// ----- design/categorical_naive_bayes_classifier_macros.svh -----
// Assertion macros for the naive Bayes classifier.
// Taken in by the classifier module, which checks its own logic; no other dependencies.
`ifndef CATEGORICAL_NAIVE_BAYES_CLASSIFIER_MACROS_SVH
`define CATEGORICAL_NAIVE_BAYES_CLASSIFIER_MACROS_SVH

// Same-cycle implication, off while reset is active.
`define CNB_ASSERT_NOW(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("cnb check failed");

// Next-cycle implication, off while reset is active.
`define CNB_ASSERT_NEXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("cnb check failed");

`endif

// ----- design/cnb_pkg.sv -----
// Shared types and constants for the naive Bayes classifier.
// Holds the command/result word structs, sizing constants and the sequencer states.
package cnb_pkg;

    localparam int COUNT_WIDTH_DEF = 8;
    localparam int NUM_VALUES      = 10;
    // Four feature counts and three powers of the opposite class total.
    localparam int NUM_FACTORS     = 7;
    localparam int STEP_W          = $clog2(NUM_FACTORS);

    localparam logic CMD_TRAIN    = 1'b0;
    localparam logic CMD_CLASSIFY = 1'b1;

    typedef struct packed {
        logic       command;
        logic [1:0] outlook;
        logic [1:0] temperature;
        logic       humidity;
        logic       wind;
        logic       label;
    } cmd_t;

    typedef struct packed {
        logic decision;
        logic class_empty;
    } result_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_CMP
    } state_t;

endpackage

// ----- design/categorical_naive_bayes_classifier.sv -----
// Train: taken in at once, busy stays low. Classify: busy is high until done rises, while
// the shared COUNT_WIDTH x COUNT_WIDTH multiplier steps 7 factors x 2 classes x 7 limbs,
// then a wide compare sets the result.
// Classify with an empty class: done the next cycle, busy stays low.
// Results cannot be stalled. Reset clears all counts and totals to zero at once.
`include "categorical_naive_bayes_classifier_macros.svh"

module categorical_naive_bayes_classifier #(
    parameter int COUNT_WIDTH = cnb_pkg::COUNT_WIDTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  cnb_pkg::cmd_t    cmd,
    output logic             busy,
    output logic             done,
    output cnb_pkg::result_t result
);

    localparam int NV    = cnb_pkg::NUM_VALUES;
    localparam int NF    = cnb_pkg::NUM_FACTORS;
    localparam int SW    = cnb_pkg::STEP_W;
    localparam int ACC_W = NF * COUNT_WIDTH;
    localparam logic [SW-1:0] LAST_STEP = SW'(NF - 1);
    localparam logic [ACC_W-1:0] ACC_ONE = ACC_W'(1);

    cnb_pkg::state_t state_reg, state_next;

    logic [COUNT_WIDTH-1:0] yes_total_reg, yes_total_next;
    logic [COUNT_WIDTH-1:0] no_total_reg, no_total_next;
    logic [COUNT_WIDTH-1:0] yes_cnt_reg [NV];
    logic [COUNT_WIDTH-1:0] yes_cnt_next [NV];
    logic [COUNT_WIDTH-1:0] no_cnt_reg [NV];
    logic [COUNT_WIDTH-1:0] no_cnt_next [NV];

    logic [COUNT_WIDTH-1:0] yes_fac_reg [NF];
    logic [COUNT_WIDTH-1:0] yes_fac_next [NF];
    logic [COUNT_WIDTH-1:0] no_fac_reg [NF];
    logic [COUNT_WIDTH-1:0] no_fac_next [NF];
    logic [ACC_W-1:0]       yes_acc_reg, yes_acc_next;
    logic [ACC_W-1:0]       no_acc_reg, no_acc_next;
    logic [COUNT_WIDTH-1:0] carry_reg, carry_next;
    logic [SW-1:0]          limb_reg, limb_next;
    logic [SW-1:0]          fidx_reg, fidx_next;
    logic                   side_reg, side_next;
    logic                   done_reg, done_next;
    cnb_pkg::result_t       result_reg, result_next;

    logic                   accept;
    logic                   train;
    logic                   classify;
    logic                   empty;
    logic [NV-1:0]          hit;
    logic [COUNT_WIDTH-1:0] sel_yes [4];
    logic [COUNT_WIDTH-1:0] sel_no [4];
    logic [COUNT_WIDTH-1:0] mul_a;
    logic [COUNT_WIDTH-1:0] mul_b;
    logic [2*COUNT_WIDTH-1:0] mul_p;

    assign busy     = (state_reg != cnb_pkg::ST_IDLE);
    assign done     = done_reg;
    assign result   = result_reg;
    assign accept   = start && !busy;
    assign train    = accept && (cmd.command == cnb_pkg::CMD_TRAIN);
    assign classify = accept && (cmd.command == cnb_pkg::CMD_CLASSIFY);
    assign empty    = (yes_total_reg == '0) || (no_total_reg == '0);

    // Slot map: outlook 0..2, temperature 3..5, humidity 6..7, wind 8..9.
    // An outlook or temperature of three hits no slot.
    assign hit[0] = (cmd.outlook == 2'd0);
    assign hit[1] = (cmd.outlook == 2'd1);
    assign hit[2] = (cmd.outlook == 2'd2);
    assign hit[3] = (cmd.temperature == 2'd0);
    assign hit[4] = (cmd.temperature == 2'd1);
    assign hit[5] = (cmd.temperature == 2'd2);
    assign hit[6] = !cmd.humidity;
    assign hit[7] = cmd.humidity;
    assign hit[8] = !cmd.wind;
    assign hit[9] = cmd.wind;

    // Pick each feature's count per class; a value with no slot counts zero.
    always_comb
    begin
        sel_yes[0] = '0;
        sel_no[0]  = '0;
        sel_yes[1] = '0;
        sel_no[1]  = '0;
        case (cmd.outlook)
            2'd0:
            begin
                sel_yes[0] = yes_cnt_reg[0];
                sel_no[0]  = no_cnt_reg[0];
            end
            2'd1:
            begin
                sel_yes[0] = yes_cnt_reg[1];
                sel_no[0]  = no_cnt_reg[1];
            end
            2'd2:
            begin
                sel_yes[0] = yes_cnt_reg[2];
                sel_no[0]  = no_cnt_reg[2];
            end
            default:
            begin
                sel_yes[0] = '0;
                sel_no[0]  = '0;
            end
        endcase
        case (cmd.temperature)
            2'd0:
            begin
                sel_yes[1] = yes_cnt_reg[3];
                sel_no[1]  = no_cnt_reg[3];
            end
            2'd1:
            begin
                sel_yes[1] = yes_cnt_reg[4];
                sel_no[1]  = no_cnt_reg[4];
            end
            2'd2:
            begin
                sel_yes[1] = yes_cnt_reg[5];
                sel_no[1]  = no_cnt_reg[5];
            end
            default:
            begin
                sel_yes[1] = '0;
                sel_no[1]  = '0;
            end
        endcase
        sel_yes[2] = cmd.humidity ? yes_cnt_reg[7] : yes_cnt_reg[6];
        sel_no[2]  = cmd.humidity ? no_cnt_reg[7]  : no_cnt_reg[6];
        sel_yes[3] = cmd.wind ? yes_cnt_reg[9] : yes_cnt_reg[8];
        sel_no[3]  = cmd.wind ? no_cnt_reg[9]  : no_cnt_reg[8];
    end

    // Training: saturating increments of the class total and its hit slots.
    always_comb
    begin
        yes_total_next = yes_total_reg;
        no_total_next  = no_total_reg;
        yes_cnt_next   = yes_cnt_reg;
        no_cnt_next    = no_cnt_reg;
        if (train)
        begin
            if (cmd.label)
            begin
                if (yes_total_reg != '1)
                    yes_total_next = yes_total_reg + 1'b1;
                for (int i = 0; i < NV; i++)
                begin
                    if (hit[i] && (yes_cnt_reg[i] != '1))
                        yes_cnt_next[i] = yes_cnt_reg[i] + 1'b1;
                end
            end
            else
            begin
                if (no_total_reg != '1)
                    no_total_next = no_total_reg + 1'b1;
                for (int i = 0; i < NV; i++)
                begin
                    if (hit[i] && (no_cnt_reg[i] != '1))
                        no_cnt_next[i] = no_cnt_reg[i] + 1'b1;
                end
            end
        end
    end

    // Shared multiplier: one limb of one accumulator times the current factor, plus carry.
    assign mul_a = side_reg ? no_acc_reg[COUNT_WIDTH-1:0] : yes_acc_reg[COUNT_WIDTH-1:0];
    assign mul_b = side_reg ? no_fac_reg[0] : yes_fac_reg[0];
    assign mul_p = ({{COUNT_WIDTH{1'b0}}, mul_a} * {{COUNT_WIDTH{1'b0}}, mul_b})
                 + {{COUNT_WIDTH{1'b0}}, carry_reg};

    always_comb
    begin
        state_next   = state_reg;
        yes_fac_next = yes_fac_reg;
        no_fac_next  = no_fac_reg;
        yes_acc_next = yes_acc_reg;
        no_acc_next  = no_acc_reg;
        carry_next   = carry_reg;
        limb_next    = limb_reg;
        fidx_next    = fidx_reg;
        side_next    = side_reg;
        done_next    = 1'b0;
        result_next  = result_reg;
        case (state_reg)
            cnb_pkg::ST_IDLE:
            begin
                if (classify)
                begin
                    if (empty)
                    begin
                        done_next               = 1'b1;
                        result_next.decision    = 1'b0;
                        result_next.class_empty = 1'b1;
                    end
                    else
                    begin
                        for (int i = 0; i < 4; i++)
                        begin
                            yes_fac_next[i] = sel_yes[i];
                            no_fac_next[i]  = sel_no[i];
                        end
                        for (int i = 4; i < NF; i++)
                        begin
                            yes_fac_next[i] = no_total_reg;
                            no_fac_next[i]  = yes_total_reg;
                        end
                        yes_acc_next = ACC_ONE;
                        no_acc_next  = ACC_ONE;
                        carry_next   = '0;
                        limb_next    = '0;
                        fidx_next    = '0;
                        side_next    = 1'b0;
                        state_next   = cnb_pkg::ST_MUL;
                    end
                end
            end
            cnb_pkg::ST_MUL:
            begin
                // Rotate the accumulator one limb down, new limb enters at the top.
                if (side_reg)
                    no_acc_next = {mul_p[COUNT_WIDTH-1:0], no_acc_reg[ACC_W-1:COUNT_WIDTH]};
                else
                    yes_acc_next = {mul_p[COUNT_WIDTH-1:0], yes_acc_reg[ACC_W-1:COUNT_WIDTH]};
                if (limb_reg == LAST_STEP)
                begin
                    // Top carry is zero: the full product fits the accumulator.
                    carry_next = '0;
                    limb_next  = '0;
                    side_next  = !side_reg;
                    if (side_reg)
                    begin
                        for (int i = 0; i < NF - 1; i++)
                        begin
                            yes_fac_next[i] = yes_fac_reg[i+1];
                            no_fac_next[i]  = no_fac_reg[i+1];
                        end
                        if (fidx_reg == LAST_STEP)
                            state_next = cnb_pkg::ST_CMP;
                        else
                            fidx_next = fidx_reg + 1'b1;
                    end
                end
                else
                begin
                    carry_next = mul_p[2*COUNT_WIDTH-1:COUNT_WIDTH];
                    limb_next  = limb_reg + 1'b1;
                end
            end
            cnb_pkg::ST_CMP:
            begin
                done_next               = 1'b1;
                result_next.decision    = (yes_acc_reg > no_acc_reg);
                result_next.class_empty = 1'b0;
                state_next              = cnb_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = cnb_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cnb_pkg::ST_IDLE;
            yes_total_reg <= '0;
            no_total_reg  <= '0;
            for (int i = 0; i < NV; i++)
            begin
                yes_cnt_reg[i] <= '0;
                no_cnt_reg[i]  <= '0;
            end
            limb_reg <= '0;
            fidx_reg <= '0;
            side_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            yes_total_reg <= yes_total_next;
            no_total_reg  <= no_total_next;
            yes_cnt_reg   <= yes_cnt_next;
            no_cnt_reg    <= no_cnt_next;
            limb_reg      <= limb_next;
            fidx_reg      <= fidx_next;
            side_reg      <= side_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        yes_fac_reg <= yes_fac_next;
        no_fac_reg  <= no_fac_next;
        yes_acc_reg <= yes_acc_next;
        no_acc_reg  <= no_acc_next;
        carry_reg   <= carry_next;
        result_reg  <= result_next;
    end

    `CNB_ASSERT_NOW(a_done_idle, clk, rst_n, done_reg, state_reg == cnb_pkg::ST_IDLE)
    `CNB_ASSERT_NOW(a_empty_says_no, clk, rst_n, done_reg && result_reg.class_empty, !result_reg.decision)
    `CNB_ASSERT_NEXT(a_classify_runs, clk, rst_n, classify && !empty, busy && !done_reg)
    `CNB_ASSERT_NEXT(a_yes_total_holds, clk, rst_n, yes_total_reg != '0, yes_total_reg != '0)
    `CNB_ASSERT_NOW(a_mul_no_train, clk, rst_n, busy, $stable(yes_total_reg) && $stable(no_total_reg))

endmodule
